// File: src/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the sprite projection pipeline
// Fixed-point widths, config register indexes, stage sideband and result types.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int FIELD_W  = 16;  // width of positions and camera vectors
    localparam int DX_W     = 17;  // signed map offset, Q9.8
    localparam int DP_W     = 32;  // direction x plane product, Q4.28
    localparam int PR_W     = 33;  // determinant and 16x17 products
    localparam int ND_W     = 34;  // numerator before scaling
    localparam int DEN1_W   = 32;  // |det|
    localparam int FRAC_SH  = 14;  // Q2.14 scale applied to numerators
    localparam int NUM1_W   = DEN1_W + FRAC_SH;  // |numerator| << 14
    localparam int T_W      = NUM1_W + 1;        // signed tx, ty
    localparam int S_W      = T_W + 1;           // tx + ty
    localparam int PP_W     = S_W / 2;           // partial product split
    localparam int DEPTH_W  = 24;
    localparam int CIDX_W   = 3;

    localparam logic signed [T_W-1:0] DEPTH_MAX = T_W'(8388607);
    localparam logic signed [T_W-1:0] DEPTH_MIN = -T_W'(8388608);

    typedef enum logic [CIDX_W-1:0] {
        CFG_CAMERA_X    = 3'd0,
        CFG_CAMERA_Y    = 3'd1,
        CFG_VIEW_DIR_X  = 3'd2,
        CFG_VIEW_DIR_Y  = 3'd3,
        CFG_CAM_PLANE_X = 3'd4,
        CFG_CAM_PLANE_Y = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic det_zero;
        logic neg_x;
        logic neg_y;
    } t_xf_side;

    typedef struct packed {
        logic                        fault;
        logic                        neg_c;
        logic signed [DEPTH_W-1:0]   depth;
    } t_sc_side;

    typedef struct packed {
        logic signed [15:0]        center_column;
        logic [13:0]               sprite_size;
        logic [7:0]                top_row;
        logic [8:0]                bottom_row;
        logic [14:0]               left_column;
        logic signed [15:0]        right_column;
        logic signed [DEPTH_W-1:0] camera_depth;
        logic                      divide_fault;
    } t_result;

endpackage

// File: src/ssp_div.sv
// ----------------------------------------------------------------------------
// ssp_div: two-lane pipelined restoring divider, shared divisor
// One quotient bit per stage; sideband rides along with the valid bit.
// ----------------------------------------------------------------------------
module ssp_div #(
    parameter int NW = 46,
    parameter int DW = 32,
    parameter int SW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num0,
    input  logic [NW-1:0] i_num1,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_q0,
    output logic [NW-1:0] o_q1,
    output logic [SW-1:0] o_side
);

    // shift one numerator bit into the remainder, subtract if it fits
    function automatic logic [DW+NW-1:0] f_step(input logic [DW-1:0] rem,
                                                input logic [NW-1:0] nq,
                                                input logic [DW-1:0] den);
        logic [DW:0] sh;
        logic [DW:0] df;
        sh = {rem, nq[NW-1]};
        df = sh - {1'b0, den};
        if (!df[DW]) begin
            return {df[DW-1:0], nq[NW-2:0], 1'b1};
        end
        return {sh[DW-1:0], nq[NW-2:0], 1'b0};
    endfunction

    logic [NW-1:0] r_v;
    logic [DW-1:0] r_rem0 [NW];
    logic [DW-1:0] r_rem1 [NW];
    logic [DW-1:0] r_den  [NW];
    logic [NW-1:0] r_q0   [NW];
    logic [NW-1:0] r_q1   [NW];
    logic [SW-1:0] r_side [NW];

    for (genvar k = 0; k < NW; k++) begin : gen_stage
        logic          w_v;
        logic [DW-1:0] w_rem0, w_rem1, w_den;
        logic [NW-1:0] w_q0, w_q1;
        logic [SW-1:0] w_side;

        if (k == 0) begin : gen_head
            assign w_v    = i_valid;
            assign w_rem0 = '0;
            assign w_rem1 = '0;
            assign w_den  = i_den;
            assign w_q0   = i_num0;
            assign w_q1   = i_num1;
            assign w_side = i_side;
        end else begin : gen_body
            assign w_v    = r_v[k-1];
            assign w_rem0 = r_rem0[k-1];
            assign w_rem1 = r_rem1[k-1];
            assign w_den  = r_den[k-1];
            assign w_q0   = r_q0[k-1];
            assign w_q1   = r_q1[k-1];
            assign w_side = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                {r_rem0[k], r_q0[k]} <= f_step(w_rem0, w_q0, w_den);
                {r_rem1[k], r_q1[k]} <= f_step(w_rem1, w_q1, w_den);
                r_den[k]             <= w_den;
                r_side[k]            <= w_side;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_q0    = r_q0[NW-1];
    assign o_q1    = r_q1[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// File: src/ssp_xform.sv
// ----------------------------------------------------------------------------
// ssp_xform: camera offset, determinant and camera-space numerators
// Four stages; ends with magnitudes and quotient signs for the divider.
// ----------------------------------------------------------------------------
module ssp_xform (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [ssp_pkg::FIELD_W-1:0]         i_sprite_x,
    input  logic [ssp_pkg::FIELD_W-1:0]         i_sprite_y,
    input  logic [ssp_pkg::FIELD_W-1:0]         i_camera_x,
    input  logic [ssp_pkg::FIELD_W-1:0]         i_camera_y,
    input  logic signed [ssp_pkg::FIELD_W-1:0]  i_view_dir_x,
    input  logic signed [ssp_pkg::FIELD_W-1:0]  i_view_dir_y,
    input  logic signed [ssp_pkg::FIELD_W-1:0]  i_cam_plane_x,
    input  logic signed [ssp_pkg::FIELD_W-1:0]  i_cam_plane_y,
    output logic                                o_valid,
    output logic [ssp_pkg::NUM1_W-1:0]          o_num_x,
    output logic [ssp_pkg::NUM1_W-1:0]          o_num_y,
    output logic [ssp_pkg::DEN1_W-1:0]          o_den,
    output ssp_pkg::t_xf_side                   o_side
);
    import ssp_pkg::*;

    logic [3:0] r_v;

    // stage A
    logic signed [DX_W-1:0] r_dx, r_dy;
    logic signed [DP_W-1:0] r_pxy, r_pyx;
    // stage B
    logic signed [PR_W-1:0] r_det_b, r_p1, r_p2, r_p3, r_p4;
    // stage C
    logic signed [PR_W-1:0] r_det_c;
    logic signed [ND_W-1:0] r_nx, r_ny;
    // stage D
    logic [NUM1_W-1:0]      r_num_x, r_num_y;
    logic [DEN1_W-1:0]      r_den;
    t_xf_side               r_side;

    logic [ND_W-1:0] n_mag_x, n_mag_y;
    logic [PR_W-1:0] n_mag_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_comb begin
        n_mag_x = r_nx[ND_W-1] ? ND_W'(-r_nx) : ND_W'(r_nx);
        n_mag_y = r_ny[ND_W-1] ? ND_W'(-r_ny) : ND_W'(r_ny);
        n_mag_d = r_det_c[PR_W-1] ? PR_W'(-r_det_c) : PR_W'(r_det_c);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= $signed({1'b0, i_sprite_x}) - $signed({1'b0, i_camera_x});
            r_dy    <= $signed({1'b0, i_sprite_y}) - $signed({1'b0, i_camera_y});
            r_pxy   <= i_cam_plane_x * i_view_dir_y;
            r_pyx   <= i_view_dir_x * i_cam_plane_y;

            r_det_b <= PR_W'(r_pxy) - PR_W'(r_pyx);
            r_p1    <= i_view_dir_y * r_dx;
            r_p2    <= i_view_dir_x * r_dy;
            r_p3    <= i_cam_plane_x * r_dy;
            r_p4    <= i_cam_plane_y * r_dx;

            r_det_c <= r_det_b;
            r_nx    <= ND_W'(r_p1) - ND_W'(r_p2);
            r_ny    <= ND_W'(r_p3) - ND_W'(r_p4);

            r_num_x         <= {n_mag_x[DEN1_W-1:0], FRAC_SH'(0)};
            r_num_y         <= {n_mag_y[DEN1_W-1:0], FRAC_SH'(0)};
            r_den           <= n_mag_d[DEN1_W-1:0];
            r_side.det_zero <= (r_det_c == '0);
            r_side.neg_x    <= r_nx[ND_W-1] ^ r_det_c[PR_W-1];
            r_side.neg_y    <= r_ny[ND_W-1] ^ r_det_c[PR_W-1];
        end
    end

    assign o_valid = r_v[3];
    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// File: src/ssp_scale.sv
// ----------------------------------------------------------------------------
// ssp_scale: signed tx/ty, depth fault and the center-column numerator
// Five stages between the two divider banks.
// ----------------------------------------------------------------------------
module ssp_scale #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    localparam int HW   = SCREEN_WIDTH / 2,
    localparam int HW_W = $clog2(HW + 1),
    localparam int CN_W = ssp_pkg::S_W + HW_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ssp_pkg::NUM1_W-1:0]  i_q_x,
    input  logic [ssp_pkg::NUM1_W-1:0]  i_q_y,
    input  ssp_pkg::t_xf_side           i_side,
    output logic                        o_valid,
    output logic [CN_W-1:0]             o_num_c,
    output logic [CN_W-1:0]             o_num_s,
    output logic [ssp_pkg::NUM1_W-1:0]  o_den,
    output ssp_pkg::t_sc_side           o_side
);
    import ssp_pkg::*;

    localparam logic [HW_W-1:0] HW_K   = HW_W'(HW);
    localparam logic [CN_W-1:0] SIZE_N = CN_W'(SCREEN_HEIGHT * 256);

    logic [4:0] r_v;

    // stage E
    logic signed [T_W-1:0] r_tx, r_ty;
    logic [NUM1_W-1:0]     r_my_e;
    logic                  r_flt_e, r_ny_e;
    // stage F
    logic signed [S_W-1:0] r_s;
    logic [NUM1_W-1:0]     r_my_f;
    logic                  r_flt_f, r_ny_f;
    logic signed [DEPTH_W-1:0] r_dep_f;
    // stage G
    logic [S_W-1:0]        r_ms;
    logic [NUM1_W-1:0]     r_my_g;
    t_sc_side              r_sd_g;
    // stage H
    logic [PP_W+HW_W-1:0]  r_pp_lo, r_pp_hi;
    logic [NUM1_W-1:0]     r_my_h;
    t_sc_side              r_sd_h;
    // stage I
    logic [CN_W-1:0]       r_num;
    logic [NUM1_W-1:0]     r_my_i;
    t_sc_side              r_sd_i;

    logic signed [DEPTH_W-1:0] n_dep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_comb begin
        if (r_ty > DEPTH_MAX) begin
            n_dep = DEPTH_W'(DEPTH_MAX);
        end else if (r_ty < DEPTH_MIN) begin
            n_dep = DEPTH_W'(DEPTH_MIN);
        end else begin
            n_dep = r_ty[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx    <= i_side.neg_x ? -$signed({1'b0, i_q_x}) : $signed({1'b0, i_q_x});
            r_ty    <= i_side.neg_y ? -$signed({1'b0, i_q_y}) : $signed({1'b0, i_q_y});
            r_my_e  <= i_q_y;
            r_flt_e <= i_side.det_zero | (i_q_y == '0);
            r_ny_e  <= i_side.neg_y;

            r_s     <= S_W'(r_tx) + S_W'(r_ty);
            r_my_f  <= r_my_e;
            r_flt_f <= r_flt_e;
            r_ny_f  <= r_ny_e;
            r_dep_f <= n_dep;

            r_ms         <= r_s[S_W-1] ? S_W'(-r_s) : S_W'(r_s);
            r_my_g       <= r_my_f;
            r_sd_g.fault <= r_flt_f;
            r_sd_g.neg_c <= r_s[S_W-1] ^ r_ny_f;
            r_sd_g.depth <= r_dep_f;

            // split the constant multiply into two narrow partial products
            r_pp_lo <= r_ms[PP_W-1:0] * HW_K;
            r_pp_hi <= r_ms[S_W-1:PP_W] * HW_K;
            r_my_h  <= r_my_g;
            r_sd_h  <= r_sd_g;

            r_num  <= (CN_W'(r_pp_hi) << PP_W) + CN_W'(r_pp_lo);
            r_my_i <= r_my_h;
            r_sd_i <= r_sd_h;
        end
    end

    assign o_valid = r_v[4];
    assign o_num_c = r_num;
    assign o_num_s = SIZE_N;
    assign o_den   = r_my_i;
    assign o_side  = r_sd_i;

endmodule

// File: src/ssp_bound.sv
// ----------------------------------------------------------------------------
// ssp_bound: saturate center and size, then clamp the draw bounds
// Two stages; a fault clears every field but the fault flag.
// ----------------------------------------------------------------------------
module ssp_bound #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    localparam int HW_W = $clog2(SCREEN_WIDTH / 2 + 1),
    localparam int CN_W = ssp_pkg::S_W + HW_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [CN_W-1:0]   i_q_c,
    input  logic [CN_W-1:0]   i_q_s,
    input  ssp_pkg::t_sc_side i_side,
    output logic              o_valid,
    output ssp_pkg::t_result  o_res
);
    import ssp_pkg::*;

    localparam int BW = 18;
    localparam logic [CN_W-1:0]      C_POS  = CN_W'(32767);
    localparam logic [CN_W-1:0]      C_NEG  = CN_W'(32768);
    localparam logic [CN_W-1:0]      S_MAX  = CN_W'(16383);
    localparam logic signed [BW-1:0] HALF_H = BW'(SCREEN_HEIGHT / 2);
    localparam logic signed [BW-1:0] LAST_H = BW'(SCREEN_HEIGHT - 1);
    localparam logic signed [BW-1:0] LAST_W = BW'(SCREEN_WIDTH - 1);

    logic [1:0] r_v;

    logic signed [15:0]        r_ctr;
    logic [13:0]               r_size;
    t_sc_side                  r_sd;
    t_result                   r_res;

    logic signed [15:0]        n_ctr;
    logic [13:0]               n_size;
    logic signed [BW-1:0]      n_half, n_top, n_bot, n_left, n_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_comb begin
        if (i_side.neg_c) begin
            n_ctr = (i_q_c > C_NEG) ? -16'sd32768 : 16'(-i_q_c);
        end else begin
            n_ctr = (i_q_c > C_POS) ? 16'sd32767 : 16'(i_q_c);
        end
        n_size = (i_q_s > S_MAX) ? 14'(S_MAX) : i_q_s[13:0];
    end

    always_comb begin
        n_half  = BW'(r_size >> 1);
        n_top   = HALF_H - n_half;
        n_bot   = n_half + HALF_H;
        n_left  = BW'(r_ctr) - n_half;
        n_right = n_half + BW'(r_ctr);
        if (n_top < 0) n_top = '0;
        if (n_bot > LAST_H) n_bot = LAST_H;
        if (n_left < 0) n_left = '0;
        if (n_right > LAST_W) n_right = LAST_W;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctr  <= n_ctr;
            r_size <= n_size;
            r_sd   <= i_side;

            if (r_sd.fault) begin
                r_res <= '{divide_fault: 1'b1, default: '0};
            end else begin
                r_res.center_column <= r_ctr;
                r_res.sprite_size   <= r_size;
                r_res.top_row       <= n_top[7:0];
                r_res.bottom_row    <= n_bot[8:0];
                r_res.left_column   <= n_left[14:0];
                r_res.right_column  <= n_right[15:0];
                r_res.camera_depth  <= r_sd.depth;
                r_res.divide_fault  <= 1'b0;
            end
        end
    end

    assign o_valid = r_v[1];
    assign o_res   = r_res;

endmodule

// File: src/sprite_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_unit: billboard sprite projection, fully pipelined
// Camera-space transform, two divider banks and draw-bound clamping.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   i_req_valid / o_req_ready, i_sprite_x/y   in
//  result    o_res_valid / i_res_ready, o_* fields      out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            in, write only
//
//  While the skid slot is empty the whole pipeline advances as one and one
//  request enters per cycle; a full skid slot holds every stage. A request
//  passes the transform, the tx/ty divider, the scale stages, the center and
//  size divider (48 + HW_W quotient bits, HW_W = clog2(SCREEN_WIDTH/2 + 1)),
//  the bound stages and the output register. Reset clears the valid bits,
//  including the output buffer's, and loads the config defaults.
// ----------------------------------------------------------------------------
module sprite_screen_projection_unit #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ssp_pkg::CIDX_W-1:0]         i_cfg_idx,
    input  logic [ssp_pkg::FIELD_W-1:0]        i_cfg_data,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  logic [15:0]                        i_sprite_x,
    input  logic [15:0]                        i_sprite_y,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic signed [15:0]                 o_center_column,
    output logic [13:0]                        o_sprite_size,
    output logic [7:0]                         o_top_row,
    output logic [8:0]                         o_bottom_row,
    output logic [14:0]                        o_left_column,
    output logic signed [15:0]                 o_right_column,
    output logic signed [23:0]                 o_camera_depth,
    output logic                               o_divide_fault
);
    import ssp_pkg::*;

    localparam int HW_W = $clog2(SCREEN_WIDTH / 2 + 1);
    localparam int CN_W = S_W + HW_W;

    // camera registers
    logic [FIELD_W-1:0]        r_camera_x, r_camera_y;
    logic signed [FIELD_W-1:0] r_view_dir_x, r_view_dir_y;
    logic signed [FIELD_W-1:0] r_cam_plane_x, r_cam_plane_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera_x    <= '0;
            r_camera_y    <= '0;
            r_view_dir_x  <= -16'sd16384;  // -1.0
            r_view_dir_y  <= '0;
            r_cam_plane_x <= '0;
            r_cam_plane_y <= 16'sd10813;   // 0.66
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAMERA_X:    r_camera_x    <= i_cfg_data;
                CFG_CAMERA_Y:    r_camera_y    <= i_cfg_data;
                CFG_VIEW_DIR_X:  r_view_dir_x  <= i_cfg_data;
                CFG_VIEW_DIR_Y:  r_view_dir_y  <= i_cfg_data;
                CFG_CAM_PLANE_X: r_cam_plane_x <= i_cfg_data;
                CFG_CAM_PLANE_Y: r_cam_plane_y <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // global advance: every stage moves unless the skid slot is occupied
    logic r_out_v, r_skid_v;
    logic w_en;
    assign w_en        = !r_skid_v;
    assign o_req_ready = w_en;

    logic              xf_v;
    logic [NUM1_W-1:0] xf_nx, xf_ny;
    logic [DEN1_W-1:0] xf_den;
    t_xf_side          xf_side;

    ssp_xform u_xform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_req_valid),
        .i_sprite_x    (i_sprite_x),
        .i_sprite_y    (i_sprite_y),
        .i_camera_x    (r_camera_x),
        .i_camera_y    (r_camera_y),
        .i_view_dir_x  (r_view_dir_x),
        .i_view_dir_y  (r_view_dir_y),
        .i_cam_plane_x (r_cam_plane_x),
        .i_cam_plane_y (r_cam_plane_y),
        .o_valid       (xf_v),
        .o_num_x       (xf_nx),
        .o_num_y       (xf_ny),
        .o_den         (xf_den),
        .o_side        (xf_side)
    );

    logic                       d1_v;
    logic [NUM1_W-1:0]          d1_qx, d1_qy;
    logic [$bits(t_xf_side)-1:0] d1_side;

    // tx and ty share the determinant as divisor
    ssp_div #(.NW(NUM1_W), .DW(DEN1_W), .SW($bits(t_xf_side))) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (xf_v),
        .i_num0  (xf_nx),
        .i_num1  (xf_ny),
        .i_den   (xf_den),
        .i_side  (xf_side),
        .o_valid (d1_v),
        .o_q0    (d1_qx),
        .o_q1    (d1_qy),
        .o_side  (d1_side)
    );

    logic              sc_v;
    logic [CN_W-1:0]   sc_nc, sc_ns;
    logic [NUM1_W-1:0] sc_den;
    t_sc_side          sc_side;

    ssp_scale #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d1_v),
        .i_q_x   (d1_qx),
        .i_q_y   (d1_qy),
        .i_side  (t_xf_side'(d1_side)),
        .o_valid (sc_v),
        .o_num_c (sc_nc),
        .o_num_s (sc_ns),
        .o_den   (sc_den),
        .o_side  (sc_side)
    );

    logic                        d2_v;
    logic [CN_W-1:0]             d2_qc, d2_qs;
    logic [$bits(t_sc_side)-1:0] d2_side;

    // center column and size share |ty| as divisor
    ssp_div #(.NW(CN_W), .DW(NUM1_W), .SW($bits(t_sc_side))) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (sc_v),
        .i_num0  (sc_nc),
        .i_num1  (sc_ns),
        .i_den   (sc_den),
        .i_side  (sc_side),
        .o_valid (d2_v),
        .o_q0    (d2_qc),
        .o_q1    (d2_qs),
        .o_side  (d2_side)
    );

    logic    bd_v;
    t_result bd_res;

    ssp_bound #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d2_v),
        .i_q_c   (d2_qc),
        .i_q_s   (d2_qs),
        .i_side  (t_sc_side'(d2_side)),
        .o_valid (bd_v),
        .o_res   (bd_res)
    );

    // output register plus one skid slot
    t_result r_out, r_skid;
    logic    w_take;
    assign w_take = r_out_v & i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;  // skid moves up, out stays valid
            end
        end else if (bd_v) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (bd_v) begin
            if (!r_out_v || w_take) begin
                r_out <= bd_res;
            end else begin
                r_skid <= bd_res;
            end
        end
    end

    assign o_res_valid     = r_out_v;
    assign o_center_column = r_out.center_column;
    assign o_sprite_size   = r_out.sprite_size;
    assign o_top_row       = r_out.top_row;
    assign o_bottom_row    = r_out.bottom_row;
    assign o_left_column   = r_out.left_column;
    assign o_right_column  = r_out.right_column;
    assign o_camera_depth  = r_out.camera_depth;
    assign o_divide_fault  = r_out.divide_fault;

endmodule
